// ----- hw/rtl/hd_pkg.sv -----
// Shared constants, types and the arctangent table for the haversine distance pipeline.
// No dependencies.
package hd_pkg;

   localparam int CORDIC_STAGES_DEF = 28;
   localparam int CW                = 40;   // CORDIC datapath width, Q30 signed
   localparam int LON_W             = 29;
   localparam int LAT_W             = 28;
   localparam int DIST_W            = 21;
   localparam int ANG_W             = 28;   // magnitude of an angle in half-microdegrees
   localparam int MAG_W             = 32;   // magnitude operand width for Q30 products

   localparam logic [31:0] HALF_UDEG_SCALE = 32'd2515284534;
   localparam logic [31:0] DIST_SCALE      = 32'd2609565204;
   localparam int          LON_LIMIT       = 180000000;
   localparam int          LAT_LIMIT       = 90000000;
   localparam int          HALF_TURN       = 180000000;
   localparam int          FULL_TURN       = 360000000;
   localparam logic signed [CW-1:0] Q_ONE  = CW'(64'd1 << 30);

   // Sideband that travels with each beat through every stage
   typedef struct packed {
      logic valid;
      logic oor;
   } stage_ctl_type;

   // round_half_up(atan(2^-i) * 2^30)
   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic [63:0] v;
      v = 64'd0;
      unique case (idx)
         0:       v = 64'd843314857;
         1:       v = 64'd497837829;
         2:       v = 64'd263043837;
         3:       v = 64'd133525159;
         4:       v = 64'd67021687;
         5:       v = 64'd33543516;
         6:       v = 64'd16775851;
         7:       v = 64'd8388437;
         8:       v = 64'd4194283;
         9:       v = 64'd2097149;
         default: begin
            if (idx <= 30)
               v = 64'd1 << (30 - idx);
            else if (idx == 31)
               v = 64'd1;
            else
               v = 64'd0;
         end
      endcase
      return $signed(v[CW-1:0]);
   endfunction

endpackage

// ----- hw/rtl/hd_if.sv -----
// Valid/ready channel interfaces for point-pair requests and distance responses.
// Depends on hd_pkg for field widths.
interface hd_req_if import hd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [LON_W-1:0] from_longitude;
   logic signed [LAT_W-1:0] from_latitude;
   logic signed [LON_W-1:0] to_longitude;
   logic signed [LAT_W-1:0] to_latitude;

   modport source (output valid, from_longitude, from_latitude, to_longitude, to_latitude,
                   input ready);
   modport sink   (input valid, from_longitude, from_latitude, to_longitude, to_latitude,
                   output ready);
endinterface

interface hd_rsp_if import hd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_centi_km;
   logic              out_of_range;

   modport source (output valid, distance_centi_km, out_of_range, input ready);
   modport sink   (input valid, distance_centi_km, out_of_range, output ready);
endinterface

// ----- hw/rtl/haversine_distance_top.sv -----
// Haversine great-circle distance, one point pair per beat, fully pipelined.
// Depends on hd_pkg, hd_if, hd_rotate and hd_vector.
//
// Takes a pair of points (microdegrees) and returns the distance on a 6371.0088 km sphere in
// hundredths of a km, rounded half up. A new pair is accepted every clock cycle unless a held
// response stalls it. Most of the depth is the three CORDIC pipelines in series (rotation,
// magnitude, final atan2), each one stage per iteration. The whole pipe stalls together when
// the response is held, so no beat is lost or repeated. An out-of-range coordinate yields
// out_of_range = 1 and distance 0.
module haversine_distance_top import hd_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   hd_req_if.sink   req,
   hd_rsp_if.source rsp
);

   localparam logic signed [LON_W:0] LonLim = (LON_W+1)'(LON_LIMIT);
   localparam logic signed [LAT_W:0] LatLim = (LAT_W+1)'(LAT_LIMIT);

   logic en;

   // Pipeline advances unless a held response blocks it
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // ---------------- stage 0: range check, angle sums and differences
   logic oor;
   logic signed [LAT_W:0]   sphi, dphi;
   logic signed [LON_W:0]   dlon;
   logic        [LON_W:0]   dlon_abs;
   logic        [ANG_W-1:0] dl_fold;

   always_comb begin
      oor = ($signed({req.from_longitude[LON_W-1], req.from_longitude}) < -LonLim) ||
            ($signed({req.from_longitude[LON_W-1], req.from_longitude}) >  LonLim) ||
            ($signed({req.to_longitude[LON_W-1],   req.to_longitude})   < -LonLim) ||
            ($signed({req.to_longitude[LON_W-1],   req.to_longitude})   >  LonLim) ||
            ($signed({req.from_latitude[LAT_W-1],  req.from_latitude})  < -LatLim) ||
            ($signed({req.from_latitude[LAT_W-1],  req.from_latitude})  >  LatLim) ||
            ($signed({req.to_latitude[LAT_W-1],    req.to_latitude})    < -LatLim) ||
            ($signed({req.to_latitude[LAT_W-1],    req.to_latitude})    >  LatLim);
      sphi = (LAT_W+1)'($signed(req.to_latitude)) + (LAT_W+1)'($signed(req.from_latitude));
      dphi = (LAT_W+1)'($signed(req.to_latitude)) - (LAT_W+1)'($signed(req.from_latitude));
      dlon = (LON_W+1)'($signed(req.to_longitude)) - (LON_W+1)'($signed(req.from_longitude));
      dlon_abs = dlon[LON_W] ? (LON_W+1)'(-dlon) : (LON_W+1)'(dlon);
      // fold a difference beyond a half turn
      if (dlon_abs > (LON_W+1)'(HALF_TURN))
         dl_fold = ANG_W'((LON_W+1)'(FULL_TURN) - dlon_abs);
      else
         dl_fold = ANG_W'(dlon_abs);
   end

   stage_ctl_type           s0_ctl_ff;
   logic signed [LAT_W:0]   s0_sphi_ff, s0_dphi_ff;
   logic        [ANG_W-1:0] s0_dl_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s0_ctl_ff <= '0;
      else if (en)
         s0_ctl_ff <= '{valid: req.valid, oor: oor};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_sphi_ff <= sphi;
         s0_dphi_ff <= dphi;
         s0_dl_ff   <= dl_fold;
      end
   end

   // ---------------- stage 1: half-microdegree to Q30 radian scaling
   logic [ANG_W-1:0] sphi_abs, dphi_abs;
   assign sphi_abs = s0_sphi_ff[LAT_W] ? ANG_W'(-s0_sphi_ff) : ANG_W'(s0_sphi_ff);
   assign dphi_abs = s0_dphi_ff[LAT_W] ? ANG_W'(-s0_dphi_ff) : ANG_W'(s0_dphi_ff);

   stage_ctl_type             s1_ctl_ff;
   logic                      s1_sphi_neg_ff, s1_dphi_neg_ff;
   logic [ANG_W+31:0]         s1_sphi_prod_ff, s1_dphi_prod_ff, s1_dl_prod_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_ctl_ff <= '0;
      else if (en)
         s1_ctl_ff <= s0_ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sphi_neg_ff  <= s0_sphi_ff[LAT_W];
         s1_dphi_neg_ff  <= s0_dphi_ff[LAT_W];
         s1_sphi_prod_ff <= sphi_abs * HALF_UDEG_SCALE;
         s1_dphi_prod_ff <= dphi_abs * HALF_UDEG_SCALE;
         s1_dl_prod_ff   <= s0_dl_ff * HALF_UDEG_SCALE;
      end
   end

   // round half up to Q30 and restore the sign
   function automatic logic signed [CW-1:0] to_q30(input logic [ANG_W+31:0] prod,
                                                  input logic neg);
      logic [ANG_W+32:0] t;
      logic [CW-1:0]     m;
      t = {1'b0, prod} + ((ANG_W+33)'(1) << 27);
      m = CW'(t[ANG_W+31:28]);
      return neg ? $signed(-m) : $signed(m);
   endfunction

   // ---------------- rotation CORDICs: cos/sin of sphi/2, dphi/2, dlam/2
   stage_ctl_type rot_ctl;
   logic [CW-1:0] cs, ss, cd, sd, cl, sl;

   hd_rotate #(.N(CORDIC_STAGES)) u_rot_s (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(s1_ctl_ff), .in_z(to_q30(s1_sphi_prod_ff, s1_sphi_neg_ff)),
      .out_ctl(rot_ctl), .out_cos(cs), .out_sin(ss)
   );

   hd_rotate #(.N(CORDIC_STAGES)) u_rot_d (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(s1_ctl_ff), .in_z(to_q30(s1_dphi_prod_ff, s1_dphi_neg_ff)),
      .out_ctl(), .out_cos(cd), .out_sin(sd)
   );

   hd_rotate #(.N(CORDIC_STAGES)) u_rot_l (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(s1_ctl_ff), .in_z(to_q30(s1_dl_prod_ff, 1'b0)),
      .out_ctl(), .out_cos(cl), .out_sin(sl)
   );

   // ---------------- stage 2: Q30 products of the split haversine terms
   stage_ctl_type        s2_ctl_ff;
   logic [2*MAG_W-1:0]   s2_p_ff, s2_q_ff, s2_r_ff, s2_t_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_ctl_ff <= '0;
      else if (en)
         s2_ctl_ff <= rot_ctl;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_p_ff <= sd[MAG_W-1:0] * cl[MAG_W-1:0];
         s2_q_ff <= cs[MAG_W-1:0] * sl[MAG_W-1:0];
         s2_r_ff <= cd[MAG_W-1:0] * cl[MAG_W-1:0];
         s2_t_ff <= ss[MAG_W-1:0] * sl[MAG_W-1:0];
      end
   end

   function automatic logic signed [CW-1:0] round_q30(input logic [2*MAG_W-1:0] prod);
      logic [2*MAG_W:0] t;
      t = {1'b0, prod} + ((2*MAG_W+1)'(1) << 29);
      return $signed(CW'(t[2*MAG_W-1:30]));
   endfunction

   // ---------------- vectoring CORDICs: magnitudes of (p, q) and (r, t)
   stage_ctl_type        vec_ctl;
   logic signed [CW-1:0] ma, mb;

   hd_vector #(.N(CORDIC_STAGES)) u_vec_a (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(s2_ctl_ff), .in_x(round_q30(s2_p_ff)), .in_y(round_q30(s2_q_ff)),
      .out_ctl(vec_ctl), .out_x(ma), .out_z()
   );

   hd_vector #(.N(CORDIC_STAGES)) u_vec_b (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(s2_ctl_ff), .in_x(round_q30(s2_r_ff)), .in_y(round_q30(s2_t_ff)),
      .out_ctl(), .out_x(mb), .out_z()
   );

   // ---------------- final atan2(sqrt a, sqrt b)
   stage_ctl_type        fin_ctl;
   logic signed [CW-1:0] zf;

   hd_vector #(.N(CORDIC_STAGES)) u_vec_f (
      .clock(clock), .reset(reset), .en(en),
      .in_ctl(vec_ctl), .in_x(mb), .in_y(ma),
      .out_ctl(fin_ctl), .out_x(), .out_z(zf)
   );

   // ---------------- stage 3: scale angle to centi-km
   logic [MAG_W-1:0] zc;
   assign zc = zf[CW-1] ? '0 : zf[MAG_W-1:0];

   stage_ctl_type      s3_ctl_ff;
   logic [2*MAG_W-1:0] s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s3_ctl_ff <= '0;
      else if (en)
         s3_ctl_ff <= fin_ctl;
   end

   always_ff @(posedge clock) begin
      if (en)
         s3_prod_ff <= zc * DIST_SCALE;
   end

   // ---------------- stage 4: round and present the response beat
   logic [2*MAG_W:0]  dist_sum;
   logic [DIST_W-1:0] dist_in;
   assign dist_sum = {1'b0, s3_prod_ff} + ((2*MAG_W+1)'(1) << 40);
   assign dist_in  = s3_ctl_ff.oor ? '0 : dist_sum[41+DIST_W-1:41];

   logic [DIST_W-1:0] dist_ff;
   logic              oor_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en)
         rsp_valid_ff <= s3_ctl_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         oor_ff  <= s3_ctl_ff.oor;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.distance_centi_km = dist_ff;
   assign rsp.out_of_range      = oor_ff;

endmodule

// ----- hw/rtl/hd_rotate.sv -----
// Pipelined CORDIC in rotation mode: one micro-rotation per register stage.
// Depends on hd_pkg (datapath width, arctangent table, sideband type).
module hd_rotate import hd_pkg::*; #(
   parameter int N = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  stage_ctl_type          in_ctl,
   input  logic signed [CW-1:0]   in_z,
   output stage_ctl_type          out_ctl,
   output logic        [CW-1:0]   out_cos,
   output logic        [CW-1:0]   out_sin
);

   stage_ctl_type        ctl_ff [N];
   logic signed [CW-1:0] x_ff   [N];
   logic signed [CW-1:0] y_ff   [N];
   logic signed [CW-1:0] z_ff   [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      stage_ctl_type        ci;
      logic signed [CW-1:0] xi, yi, zi;

      if (g == 0) begin : g_first
         assign ci = in_ctl;
         assign xi = Q_ONE;
         assign yi = '0;
         assign zi = in_z;
      end else begin : g_next
         assign ci = ctl_ff[g-1];
         assign xi = x_ff[g-1];
         assign yi = y_ff[g-1];
         assign zi = z_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset)
            ctl_ff[g] <= '0;
         else if (en)
            ctl_ff[g] <= ci;
      end

      // rotate toward zero residual angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (zi >= 0) begin
               x_ff[g] <= xi - (yi >>> g);
               y_ff[g] <= yi + (xi >>> g);
               z_ff[g] <= zi - atan_q30(g);
            end else begin
               x_ff[g] <= xi + (yi >>> g);
               y_ff[g] <= yi - (xi >>> g);
               z_ff[g] <= zi + atan_q30(g);
            end
         end
      end
   end

   assign out_ctl = ctl_ff[N-1];
   assign out_cos = x_ff[N-1][CW-1] ? CW'(-x_ff[N-1]) : CW'(x_ff[N-1]);
   assign out_sin = y_ff[N-1][CW-1] ? CW'(-y_ff[N-1]) : CW'(y_ff[N-1]);

endmodule

// ----- hw/rtl/hd_vector.sv -----
// Pipelined CORDIC in vectoring mode: gives the scaled magnitude and the angle of (x, y).
// Depends on hd_pkg (datapath width, arctangent table, sideband type).
module hd_vector import hd_pkg::*; #(
   parameter int N = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  stage_ctl_type          in_ctl,
   input  logic signed [CW-1:0]   in_x,
   input  logic signed [CW-1:0]   in_y,
   output stage_ctl_type          out_ctl,
   output logic signed [CW-1:0]   out_x,
   output logic signed [CW-1:0]   out_z
);

   stage_ctl_type        ctl_ff [N];
   logic signed [CW-1:0] x_ff   [N];
   logic signed [CW-1:0] y_ff   [N];
   logic signed [CW-1:0] z_ff   [N];

   for (genvar g = 0; g < N; g++) begin : g_stage
      stage_ctl_type        ci;
      logic signed [CW-1:0] xi, yi, zi;

      if (g == 0) begin : g_first
         assign ci = in_ctl;
         assign xi = in_x;
         assign yi = in_y;
         assign zi = '0;
      end else begin : g_next
         assign ci = ctl_ff[g-1];
         assign xi = x_ff[g-1];
         assign yi = y_ff[g-1];
         assign zi = z_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset)
            ctl_ff[g] <= '0;
         else if (en)
            ctl_ff[g] <= ci;
      end

      // drive y toward zero, accumulating the angle
      always_ff @(posedge clock) begin
         if (en) begin
            if (yi > 0) begin
               x_ff[g] <= xi + (yi >>> g);
               y_ff[g] <= yi - (xi >>> g);
               z_ff[g] <= zi + atan_q30(g);
            end else begin
               x_ff[g] <= xi - (yi >>> g);
               y_ff[g] <= yi + (xi >>> g);
               z_ff[g] <= zi - atan_q30(g);
            end
         end
      end
   end

   assign out_ctl = ctl_ff[N-1];
   assign out_x   = x_ff[N-1];
   assign out_z   = z_ff[N-1];

endmodule

// ----- hw/rtl/hd_checker.sv -----
// Port-level checks for the haversine distance pipeline, bound to the top level.
// Depends on hd_pkg and haversine_distance_top.
module hd_checker import hd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_distance_centi_km,
   input logic              rsp_out_of_range
);

   // half the circumference (about 2001511) plus slack for the CORDIC angle error
   localparam logic [DIST_W-1:0] DistBound = DIST_W'(2001600);

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_centi_km)
                                  && $stable(rsp_out_of_range))
      else $error("response beat changed while stalled");

   // the whole pipe stalls only behind a held response
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response backpressure");

   // illegal coordinates report zero distance
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_distance_centi_km == '0)
      else $error("out-of-range beat carries a distance");

   // no distance beyond half the circumference
   a_dist_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance_centi_km <= DistBound)
      else $error("distance exceeds half circumference");

   // nothing emerges right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind haversine_distance_top hd_checker u_hd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_distance_centi_km (rsp.distance_centi_km),
   .rsp_out_of_range      (rsp.out_of_range)
);

// ----- tb/sv/tb.sv -----
// Testbench for haversine_distance_top: streams point pairs, predicts each distance
// with a bit-exact fixed-point CORDIC model and checks every response beat.
// Depends on hd_pkg, hd_if and the haversine_distance_top RTL.
module tb;
   import hd_pkg::*;

   localparam int STAGES      = CORDIC_STAGES_DEF;
   localparam int LATENCY     = 3 * STAGES + 5;
   localparam int N_RANDOM    = 1230;
   localparam int CYCLE_LIMIT = 300000;
   localparam int STALL_LEN   = 600;

   typedef struct {
      bit                      drain;   // pause marker: wait until all responses are in
      logic signed [LON_W-1:0] lon1;
      logic signed [LAT_W-1:0] lat1;
      logic signed [LON_W-1:0] lon2;
      logic signed [LAT_W-1:0] lat2;
   } pair_type;

   typedef struct {
      logic [DIST_W-1:0] centi_km;
      logic              oor;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hd_req_if req_bus ();
   hd_rsp_if rsp_bus ();

   haversine_distance_top #(.CORDIC_STAGES(STAGES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pair_type   pair_q[$];
   result_type dist_q[$];
   longint     arctan_q30[60];
   int         n_sent, n_checked, n_oor, n_errors, n_cycles;
   int         stall_left;
   bit         stall_done;

   // ---------------- fixed-point predictor ----------------
   function automatic longint arctan_entry(int i);
      longint unsigned acc;
      longint unsigned term;
      int e;
      if (i == 0) return 64'd843314857;
      acc = 0;
      for (int k = 0; k < 60; k++) begin
         e = i * (2 * k + 1);
         if (e >= 60) break;
         term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
         if (k % 2) acc -= term; else acc += term;
      end
      return longint'((acc + (64'd1 << 29)) >> 30);
   endfunction

   function automatic longint angle_q30(longint v);
      longint unsigned u;
      longint unsigned r;
      u = (v < 0) ? -v : v;
      r = (u * 64'd2515284534 + (64'd1 << 27)) >> 28;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic void cordic_rotate(longint z, output longint unsigned cmag,
                                         output longint unsigned smag);
      longint x, y, dx, dy;
      x = 64'd1 << 30;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_q30[i];
         end else begin
            x += dx; y -= dy; z += arctan_q30[i];
         end
      end
      cmag = (x < 0) ? -x : x;
      smag = (y < 0) ? -y : y;
   endfunction

   function automatic void cordic_vector(longint xi, longint yi, output longint mag,
                                         output longint ang);
      longint x, y, z, dx, dy;
      x = xi; y = yi; z = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_q30[i];
         end else begin
            x -= dx; y += dy; z -= arctan_q30[i];
         end
      end
      mag = x;
      ang = z;
   endfunction

   function automatic longint mul_q30(longint unsigned a, longint unsigned b);
      return longint'((a * b + (64'd1 << 29)) >> 30);
   endfunction

   function automatic result_type great_circle(pair_type p);
      result_type      d;
      longint          lo1, la1, lo2, la2, dl, ma, mb, z, dummy;
      longint unsigned cs, ss, cd, sd, cl, sl, scaled;
      lo1 = p.lon1; la1 = p.lat1; lo2 = p.lon2; la2 = p.lat2;
      d.centi_km = '0;
      d.oor      = 1'b0;
      if (lo1 < -LON_LIMIT || lo1 > LON_LIMIT || lo2 < -LON_LIMIT || lo2 > LON_LIMIT ||
          la1 < -LAT_LIMIT || la1 > LAT_LIMIT || la2 < -LAT_LIMIT || la2 > LAT_LIMIT) begin
         d.oor = 1'b1;
         return d;
      end
      dl = lo2 - lo1;
      if (dl < 0) dl = -dl;
      if (dl > HALF_TURN) dl = FULL_TURN - dl;
      cordic_rotate(angle_q30(la1 + la2), cs, ss);
      cordic_rotate(angle_q30(la2 - la1), cd, sd);
      cordic_rotate(angle_q30(dl), cl, sl);
      cordic_vector(mul_q30(sd, cl), mul_q30(cs, sl), ma, dummy);
      cordic_vector(mul_q30(cd, cl), mul_q30(ss, sl), mb, dummy);
      cordic_vector(mb, ma, dummy, z);
      if (z < 0) z = 0;
      scaled = (longint'(z) * 64'd2609565204 + (64'd1 << 40)) >> 41;
      d.centi_km = scaled[DIST_W-1:0];
      return d;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic pair_type make_pair(longint a, longint b, longint c, longint e);
      pair_type p;
      p.drain = 0;
      p.lon1 = a[LON_W-1:0]; p.lat1 = b[LAT_W-1:0];
      p.lon2 = c[LON_W-1:0]; p.lat2 = e[LAT_W-1:0];
      return p;
   endfunction

   function automatic pair_type drain_marker();
      pair_type p;
      p = make_pair(0, 0, 0, 0);
      p.drain = 1;
      return p;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(0, 2 * LON_LIMIT)) - LON_LIMIT;
   endfunction

   function automatic longint rand_lat();
      return longint'($urandom_range(0, 2 * LAT_LIMIT)) - LAT_LIMIT;
   endfunction

   // quiet window: no random idling on either side while the count of sent pairs is from 400 to 599
   function automatic bit quiet_window();
      return (n_sent >= 400 && n_sent < 600);
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pair_type acc;
            acc.drain = 0;
            acc.lon1 = req_bus.from_longitude; acc.lat1 = req_bus.from_latitude;
            acc.lon2 = req_bus.to_longitude;   acc.lat2 = req_bus.to_latitude;
            dist_q.push_back(great_circle(acc));
            n_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pair_q.size() > 0 && pair_q[0].drain &&
                dist_q.size() == 0 && !(req_bus.valid && req_bus.ready))
               void'(pair_q.pop_front());
            if (pair_q.size() > 0 && !pair_q[0].drain &&
                (quiet_window() || $urandom_range(0, 99) >= 36)) begin
               pair_type nx;
               nx = pair_q.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.from_longitude <= nx.lon1;
               req_bus.from_latitude  <= nx.lat1;
               req_bus.to_longitude   <= nx.lon2;
               req_bus.to_latitude    <= nx.lat2;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver and checker ----------------
   always @(posedge clock) begin
      n_cycles++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (dist_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("ERROR: response beat with no pair outstanding: dist=%0d oor=%0b",
                           rsp_bus.distance_centi_km, rsp_bus.out_of_range);
            end else begin
               result_type want;
               want = dist_q.pop_front();
               if (rsp_bus.distance_centi_km !== want.centi_km ||
                   rsp_bus.out_of_range !== want.oor) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("ERROR: beat %0d expected dist=%0d oor=%0b, got dist=%0d oor=%0b",
                              n_checked, want.centi_km, want.oor,
                              rsp_bus.distance_centi_km, rsp_bus.out_of_range);
               end
               if (want.oor) n_oor++;
               n_checked++;
            end
         end
         // one long hold-off, so the pipe fills and back-pressures the sender
         if (!stall_done && n_sent >= 800) begin
            stall_done <= 1'b1;
            stall_left <= STALL_LEN;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet_window() || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   // ---------------- timeout ----------------
   always @(posedge clock) begin
      if (n_cycles > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", n_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      req_bus.valid          = 1'b0;
      req_bus.from_longitude = '0;
      req_bus.from_latitude  = '0;
      req_bus.to_longitude   = '0;
      req_bus.to_latitude    = '0;
      rsp_bus.ready          = 1'b0;
      n_sent = 0; n_checked = 0; n_oor = 0; n_errors = 0; n_cycles = 0;
      stall_left = 0; stall_done = 0;
      for (int i = 0; i < 60; i++) arctan_q30[i] = arctan_entry(i);

      // directed: zero distance, poles, antipodes, date line, extremes, illegal values
      pair_q.push_back(make_pair(0, 0, 0, 0));
      pair_q.push_back(make_pair(123456789, -45678901, 123456789, -45678901));
      pair_q.push_back(make_pair(0, LAT_LIMIT, 0, -LAT_LIMIT));
      pair_q.push_back(make_pair(0, 0, LON_LIMIT, 0));
      pair_q.push_back(make_pair(-LON_LIMIT, 0, LON_LIMIT, 0));
      pair_q.push_back(make_pair(-LON_LIMIT, -LAT_LIMIT, LON_LIMIT, LAT_LIMIT));
      pair_q.push_back(make_pair(179000000, 10000000, -179000000, -10000000));
      pair_q.push_back(make_pair(-170000000, 50000000, 175000000, 51000000));
      pair_q.push_back(make_pair(90000000, 0, -90000000, 0));
      pair_q.push_back(make_pair(0, 89999999, 180000000, 89999999));
      pair_q.push_back(make_pair(0, 0, 1, 0));
      pair_q.push_back(make_pair(0, 0, 0, 1));
      pair_q.push_back(make_pair(116397000, 39909000, 121473000, 31230000));
      pair_q.push_back(make_pair(LON_LIMIT + 1, 0, 0, 0));
      pair_q.push_back(make_pair(0, -LAT_LIMIT - 1, 0, 0));
      pair_q.push_back(make_pair(0, 0, -LON_LIMIT - 1, 0));
      pair_q.push_back(make_pair(0, 0, 0, LAT_LIMIT + 1));
      pair_q.push_back(make_pair(-(64'd1 << 28), -(64'd1 << 27), (64'd1 << 28) - 1,
                                 (64'd1 << 27) - 1));
      pair_q.push_back(make_pair((64'd1 << 28) - 1, (64'd1 << 27) - 1, -(64'd1 << 28),
                                 -(64'd1 << 27)));
      pair_q.push_back(make_pair(-1, -1, -1, -1));
      pair_q.push_back(drain_marker());

      // random: mostly legal pairs, some with close longitudes, some raw noise often out of range
      for (int i = 0; i < N_RANDOM; i++) begin
         int sel;
         sel = $urandom_range(0, 99);
         if (i == N_RANDOM / 3) pair_q.push_back(drain_marker());
         if (sel < 80) begin
            pair_q.push_back(make_pair(rand_lon(), rand_lat(), rand_lon(), rand_lat()));
         end else if (sel < 88) begin
            pair_q.push_back(make_pair(rand_lon(), rand_lat(),
                                       rand_lon() + longint'($urandom_range(0, 2000)) - 1000,
                                       rand_lat()));
            pair_q[$].lon2 = pair_q[$ - 0].lon1 + $signed(LON_W'($urandom_range(0, 2000)) -
                             LON_W'(1000));
            if (pair_q[$].lon2 > LON_LIMIT || pair_q[$].lon2 < -LON_LIMIT)
               pair_q[$].lon2 = pair_q[$].lon1;
         end else begin
            pair_q.push_back(make_pair(longint'($signed(LON_W'($urandom()))),
                                       longint'($signed(LAT_W'($urandom()))),
                                       longint'($signed(LON_W'($urandom()))),
                                       longint'($signed(LAT_W'($urandom())))));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pair_q.size() == 0 && !req_bus.valid && dist_q.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);

      if (dist_q.size() != 0) begin
         n_errors++;
         $display("ERROR: %0d responses never arrived", dist_q.size());
      end
      $display("Checked %0d distances (%0d out of range) from %0d pairs in %0d cycles,",
               n_checked, n_oor, n_sent, n_cycles);
      $display("with random idling, a %0d-cycle receiver hold-off and two drain pauses.",
               STALL_LEN);
      if (n_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/hd_pkg.sv
hw/rtl/hd_if.sv
hw/rtl/hd_rotate.sv
hw/rtl/hd_vector.sv
hw/rtl/haversine_distance_top.sv
hw/rtl/hd_checker.sv
tb/sv/tb.sv
